[hdl/bdv_pkg.sv]
// bdv_pkg: shared types, constants and character classes for the barcode
// data validator. No dependencies; every other file depends on it.
`timescale 1ns / 1ps

package bdv_pkg;

  // Length counters saturate at MAX_LEN
  localparam int MAX_LEN = 256;
  localparam int LEN_W   = $clog2(MAX_LEN + 1);
  localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(MAX_LEN);

  // Position sums saturate at their full width
  localparam int SUM_W = 12;
  localparam logic [SUM_W-1:0] SUM_MAX = '1;

  localparam int CHAR_W    = 8;
  localparam int SYM_W     = 4;
  localparam int DIGIT_W   = 4;
  localparam int VERDICT_W = 3;

  // Symbology codes
  localparam logic [SYM_W-1:0] SYM_EAN13   = 4'd0;
  localparam logic [SYM_W-1:0] SYM_JAN13   = 4'd1;
  localparam logic [SYM_W-1:0] SYM_EAN8    = 4'd2;
  localparam logic [SYM_W-1:0] SYM_JAN8    = 4'd3;
  localparam logic [SYM_W-1:0] SYM_UPCA    = 4'd4;
  localparam logic [SYM_W-1:0] SYM_UPCE    = 4'd5;
  localparam logic [SYM_W-1:0] SYM_ITF     = 4'd6;
  localparam logic [SYM_W-1:0] SYM_CODABAR = 4'd7;
  localparam logic [SYM_W-1:0] SYM_CODE39  = 4'd8;

  // Verdict codes
  typedef enum logic [VERDICT_W-1:0] {
    VERDICT_OK         = 3'd0,
    VERDICT_NO_BARCODE = 3'd1,
    VERDICT_FORMAT     = 3'd2,
    VERDICT_TYPE       = 3'd3,
    VERDICT_CHECK      = 3'd4
  } bdv_verdict_t;

  // ASCII codes used by the checks
  localparam logic [CHAR_W-1:0] CHAR_SPACE   = 8'h20;
  localparam logic [CHAR_W-1:0] CHAR_DOLLAR  = 8'h24;
  localparam logic [CHAR_W-1:0] CHAR_PERCENT = 8'h25;
  localparam logic [CHAR_W-1:0] CHAR_PLUS    = 8'h2B;
  localparam logic [CHAR_W-1:0] CHAR_MINUS   = 8'h2D;
  localparam logic [CHAR_W-1:0] CHAR_DOT     = 8'h2E;
  localparam logic [CHAR_W-1:0] CHAR_SLASH   = 8'h2F;
  localparam logic [CHAR_W-1:0] CHAR_ZERO    = 8'h30;
  localparam logic [CHAR_W-1:0] CHAR_NINE    = 8'h39;
  localparam logic [CHAR_W-1:0] CHAR_COLON   = 8'h3A;
  localparam logic [CHAR_W-1:0] CHAR_UPPER_A = 8'h41;
  localparam logic [CHAR_W-1:0] CHAR_UPPER_D = 8'h44;
  localparam logic [CHAR_W-1:0] CHAR_UPPER_Z = 8'h5A;
  localparam logic [CHAR_W-1:0] CHAR_LOWER_A = 8'h61;
  localparam logic [CHAR_W-1:0] CHAR_LOWER_Z = 8'h7A;

  // Running state of one string
  typedef struct packed {
    logic [LEN_W-1:0]   main_length;
    logic [LEN_W-1:0]   addon_length;
    logic               in_addon;
    logic [SUM_W-1:0]   even_sum;
    logic [SUM_W-1:0]   odd_sum;
    logic [DIGIT_W-1:0] last_digit;
    logic [CHAR_W-1:0]  first_char;
    logic [CHAR_W-1:0]  previous_char;
    logic               main_nondigit;
    logic               addon_nondigit;
    logic               interior_bad;
  } bdv_state_t;

  function automatic logic is_digit(input logic [CHAR_W-1:0] c);
    return (c >= CHAR_ZERO) && (c <= CHAR_NINE);
  endfunction

  function automatic logic is_alpha(input logic [CHAR_W-1:0] c);
    return ((c >= CHAR_UPPER_A) && (c <= CHAR_UPPER_Z)) ||
           ((c >= CHAR_LOWER_A) && (c <= CHAR_LOWER_Z));
  endfunction

  function automatic logic is_end_mark(input logic [CHAR_W-1:0] c);
    return (c >= CHAR_UPPER_A) && (c <= CHAR_UPPER_D);
  endfunction

  function automatic logic codabar_inner_ok(input logic [CHAR_W-1:0] c);
    return is_digit(c) || (c == CHAR_MINUS) || (c == CHAR_DOLLAR) ||
           (c == CHAR_COLON) || (c == CHAR_SLASH) || (c == CHAR_PLUS) ||
           (c == CHAR_DOT);
  endfunction

  function automatic logic code39_ok(input logic [CHAR_W-1:0] c);
    return is_digit(c) || is_alpha(c) || (c == CHAR_MINUS) || (c == CHAR_DOT) ||
           (c == CHAR_DOLLAR) || (c == CHAR_SLASH) || (c == CHAR_PLUS) ||
           (c == CHAR_PERCENT) || (c == CHAR_SPACE);
  endfunction

endpackage

[hdl/bdv_if.sv]
// bdv_if: valid/ready channel interfaces for character words in and
// verdict words out. Depends on bdv_pkg for field widths.
`timescale 1ns / 1ps

interface bdv_char_if;
  logic                       valid;
  logic                       ready;
  logic [bdv_pkg::CHAR_W-1:0] char_byte;
  logic                       no_char;
  logic                       last;

  modport source (output valid, output char_byte, output no_char, output last,
                  input ready);
  modport sink   (input valid, input char_byte, input no_char, input last,
                  output ready);
endinterface

interface bdv_verdict_if;
  logic                          valid;
  logic                          ready;
  logic [bdv_pkg::VERDICT_W-1:0] verdict;

  modport source (output valid, output verdict, input ready);
  modport sink   (input valid, input verdict, output ready);
endinterface

[hdl/bdv_accum.sv]
// bdv_accum: running lengths, digit sums and character flags of the string
// being received. Depends on bdv_pkg.
`timescale 1ns / 1ps

module bdv_accum (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [bdv_pkg::SYM_W-1:0]   symbology,
  input  logic                        step,
  input  logic [bdv_pkg::CHAR_W-1:0]  char_byte,
  input  logic                        no_char,
  input  logic                        last,
  output bdv_pkg::bdv_state_t         upd
);
  import bdv_pkg::*;

  bdv_state_t          cur;
  bdv_state_t          cur_next;
  logic                ean;
  logic [DIGIT_W-1:0]  digit;
  logic [SUM_W:0]      sum_wide;
  logic [SUM_W-1:0]    sum_sel;

  assign ean   = (symbology <= SYM_UPCE);
  assign digit = DIGIT_W'(char_byte - CHAR_ZERO);

  // digit goes to the sum picked by the parity of its index
  assign sum_sel  = cur.main_length[0] ? cur.odd_sum : cur.even_sum;
  assign sum_wide = {1'b0, sum_sel} + (SUM_W + 1)'(digit);

  // state after taking this word's character
  always_comb begin
    upd = cur;
    if (!no_char) begin
      if (ean && cur.in_addon) begin
        if (cur.addon_length != LEN_MAX) upd.addon_length = cur.addon_length + 1'b1;
        if (!is_digit(char_byte)) upd.addon_nondigit = 1'b1;
      end else if (ean && (char_byte == CHAR_SPACE)) begin
        upd.in_addon = 1'b1;
      end else begin
        // interior checks look at the character before this one
        if ((symbology == SYM_CODABAR) && (cur.main_length >= LEN_W'(2)) &&
            !codabar_inner_ok(cur.previous_char)) upd.interior_bad = 1'b1;
        if ((symbology == SYM_CODE39) && (cur.main_length != '0) &&
            !code39_ok(cur.previous_char)) upd.interior_bad = 1'b1;
        if (cur.main_length == '0) upd.first_char = char_byte;
        if (is_digit(char_byte)) begin
          if (cur.main_length[0]) begin
            upd.odd_sum = (sum_wide > {1'b0, SUM_MAX}) ? SUM_MAX : sum_wide[SUM_W-1:0];
          end else begin
            upd.even_sum = (sum_wide > {1'b0, SUM_MAX}) ? SUM_MAX : sum_wide[SUM_W-1:0];
          end
          upd.last_digit = digit;
        end else begin
          upd.main_nondigit = 1'b1;
        end
        upd.previous_char = char_byte;
        if (cur.main_length != LEN_MAX) upd.main_length = cur.main_length + 1'b1;
      end
    end
  end

  // a string's end returns the state to its cleared form
  always_comb begin
    cur_next = cur;
    if (step) begin
      cur_next = last ? '0 : upd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur <= '0;
    end else begin
      cur <= cur_next;
    end
  end

endmodule

[hdl/bdv_judge.sv]
// bdv_judge: verdict of a finished string, including the mod-10 check digit.
// Depends on bdv_pkg.
`timescale 1ns / 1ps

module bdv_judge (
  input  logic [bdv_pkg::SYM_W-1:0] symbology,
  input  bdv_pkg::bdv_state_t       snap,
  output bdv_pkg::bdv_verdict_t     verdict
);
  import bdv_pkg::*;

  localparam int TOT_W = SUM_W + 2;
  localparam int RCP_W = 13;
  localparam int PRD_W = TOT_W + RCP_W;
  // floor(2^16 / 10), slightly low so the quotient is never too large
  localparam logic [RCP_W-1:0] RECIP_10 = 13'd6553;
  localparam int RCP_SHIFT = 16;

  logic [LEN_W-1:0]    n;
  logic [SUM_W-1:0]    w3;
  logic [SUM_W-1:0]    w1_raw;
  logic [SUM_W-1:0]    w1;
  logic [TOT_W-1:0]    total;
  logic [PRD_W-1:0]    prod;
  logic [TOT_W-1:0]    quot;
  logic [TOT_W-1:0]    rem_raw;
  logic [TOT_W-1:0]    rem_fix;
  logic [DIGIT_W-1:0]  calc;
  logic                cd_ok;
  logic                ean;

  assign n   = snap.main_length;
  assign ean = (symbology <= SYM_UPCE);

  // weight 3 falls on the sum whose parity matches the length
  assign w3     = n[0] ? snap.odd_sum : snap.even_sum;
  assign w1_raw = n[0] ? snap.even_sum : snap.odd_sum;
  assign w1     = (w1_raw >= SUM_W'(snap.last_digit)) ?
                  w1_raw - SUM_W'(snap.last_digit) : '0;
  assign total  = TOT_W'(w3) * TOT_W'(3) + TOT_W'(w1);

  // total mod 10 by reciprocal, then one correction
  assign prod    = PRD_W'(total) * PRD_W'(RECIP_10);
  assign quot    = TOT_W'(prod >> RCP_SHIFT);
  assign rem_raw = total - quot * TOT_W'(10);
  assign rem_fix = (rem_raw >= TOT_W'(10)) ? rem_raw - TOT_W'(10) : rem_raw;
  assign calc    = (rem_fix == '0) ? '0 : DIGIT_W'(TOT_W'(10) - rem_fix);
  assign cd_ok   = (calc == snap.last_digit);

  // checks in their order of precedence
  always_comb begin
    verdict = VERDICT_OK;
    priority if (n == '0) begin
      verdict = VERDICT_NO_BARCODE;
    end else if (ean && (snap.addon_length != '0) &&
                 (snap.addon_length != LEN_W'(2)) && (snap.addon_length != LEN_W'(5))) begin
      verdict = VERDICT_FORMAT;
    end else if (ean && (snap.addon_length != '0) && snap.addon_nondigit) begin
      verdict = VERDICT_TYPE;
    end else if (ean && snap.main_nondigit) begin
      verdict = VERDICT_TYPE;
    end else begin
      unique case (symbology)
        SYM_EAN13, SYM_JAN13: begin
          if ((n != LEN_W'(12)) && (n != LEN_W'(13))) verdict = VERDICT_FORMAT;
          else if ((n == LEN_W'(13)) && !cd_ok) verdict = VERDICT_CHECK;
        end
        SYM_EAN8, SYM_JAN8: begin
          if ((n != LEN_W'(7)) && (n != LEN_W'(8))) verdict = VERDICT_TYPE;
          else if ((n == LEN_W'(8)) && !cd_ok) verdict = VERDICT_CHECK;
        end
        SYM_UPCA: begin
          if ((n != LEN_W'(11)) && (n != LEN_W'(12))) verdict = VERDICT_TYPE;
          else if ((n == LEN_W'(12)) && !cd_ok) verdict = VERDICT_CHECK;
        end
        SYM_UPCE: begin
          if ((n != LEN_W'(6)) && (n != LEN_W'(7))) verdict = VERDICT_TYPE;
        end
        SYM_ITF: begin
          if (snap.main_nondigit) verdict = VERDICT_TYPE;
        end
        SYM_CODABAR: begin
          if (!is_end_mark(snap.first_char) || !is_end_mark(snap.previous_char) ||
              snap.interior_bad) verdict = VERDICT_TYPE;
        end
        SYM_CODE39: begin
          if (snap.interior_bad) verdict = VERDICT_TYPE;
        end
        default: begin
          verdict = VERDICT_OK;
        end
      endcase
    end
  end

endmodule

[hdl/barcode_data_validator_unit.sv]
// barcode_data_validator_unit: top level of the barcode data validator.
// Depends on bdv_pkg, bdv_if, bdv_accum and bdv_judge.
//
//   channel    | dir | handshake     | word
//   -----------+-----+---------------+-------------------------------
//   chars      | in  | valid/ready   | char_byte[7:0], no_char, last
//   verdicts   | out | valid/ready   | verdict[2:0]
//   cfg        | in  | cfg_we        | cfg_wdata[3:0] (symbology)
//
// One character word is taken per cycle while chars.ready is high. Each word
// is registered, then folds into the running state. A last word's state is
// captured into the capture register and then judged into the output register.
// Up to three verdicts can be queued (input, capture and output registers)
// before chars.ready falls. Synchronous reset clears all valids and the
// running state and sets the symbology to EAN13.
`timescale 1ns / 1ps

module barcode_data_validator_unit (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [bdv_pkg::SYM_W-1:0] cfg_wdata,
  bdv_char_if.sink                  chars,
  bdv_verdict_if.source             verdicts
);
  import bdv_pkg::*;

  logic [SYM_W-1:0]  symbology;

  logic              ireg_valid;
  logic [CHAR_W-1:0] ireg_char;
  logic              ireg_no_char;
  logic              ireg_last;

  logic              snap_valid;
  bdv_state_t        snap;
  bdv_state_t        upd;

  logic              out_valid;
  bdv_verdict_t      out_verdict;
  bdv_verdict_t      judged;

  logic              out_free;
  logic              snap_fire;
  logic              snap_free;
  logic              ireg_fire;
  logic              in_fire;

  // flow control between the three stages
  assign out_free  = !out_valid || verdicts.ready;
  assign snap_fire = snap_valid && out_free;
  assign snap_free = !snap_valid || out_free;
  assign ireg_fire = ireg_valid && (!ireg_last || snap_free);
  assign chars.ready = !ireg_valid || ireg_fire;
  assign in_fire   = chars.valid && chars.ready;

  assign verdicts.valid   = out_valid;
  assign verdicts.verdict = out_verdict;

  // symbology register
  always_ff @(posedge clk) begin
    if (rst) begin
      symbology <= SYM_EAN13;
    end else if (cfg_we) begin
      symbology <= cfg_wdata;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      ireg_valid <= 1'b0;
    end else if (in_fire) begin
      ireg_valid <= 1'b1;
    end else if (ireg_fire) begin
      ireg_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      ireg_char    <= chars.char_byte;
      ireg_no_char <= chars.no_char;
      ireg_last    <= chars.last;
    end
  end

  // running state
  bdv_accum u_accum (
    .clk       (clk),
    .rst       (rst),
    .symbology (symbology),
    .step      (ireg_fire),
    .char_byte (ireg_char),
    .no_char   (ireg_no_char),
    .last      (ireg_last),
    .upd       (upd)
  );

  // capture of a finished string's state
  always_ff @(posedge clk) begin
    if (rst) begin
      snap_valid <= 1'b0;
    end else if (ireg_fire && ireg_last) begin
      snap_valid <= 1'b1;
    end else if (snap_fire) begin
      snap_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ireg_fire && ireg_last) begin
      snap <= upd;
    end
  end

  bdv_judge u_judge (
    .symbology (symbology),
    .snap      (snap),
    .verdict   (judged)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (snap_fire) begin
      out_valid <= 1'b1;
    end else if (verdicts.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (snap_fire) begin
      out_verdict <= judged;
    end
  end

endmodule

[hdl/bdv_checker.sv]
// bdv_checker: port-level assertions for barcode_data_validator_unit, bound
// to the top level. Depends on bdv_pkg for widths.
`timescale 1ns / 1ps

module bdv_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          in_last,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [bdv_pkg::VERDICT_W-1:0] verdict
);
  import bdv_pkg::*;

  logic [2:0] pending;
  logic       in_last_fire;
  logic       out_fire;

  assign in_last_fire = in_valid && in_ready && in_last;
  assign out_fire     = out_valid && out_ready;

  // strings ended but verdict not yet delivered
  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else if (in_last_fire && !out_fire) begin
      pending <= pending + 1'b1;
    end else if (!in_last_fire && out_fire) begin
      pending <= pending - 1'b1;
    end
  end

  a_no_invented_verdict: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (pending != '0))
    else $error("verdict shown with no finished string outstanding");

  a_queue_bounded: assert property (@(posedge clk) disable iff (rst)
    pending <= 3'd3)
    else $error("more than three verdicts outstanding");

  a_ready_only_on_backpressure: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> (out_valid && !out_ready))
    else $error("input stalled while the output side is free");

  a_verdict_held: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(verdict)))
    else $error("stalled verdict changed or dropped");

endmodule

bind barcode_data_validator_unit bdv_checker u_bdv_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (chars.valid),
  .in_ready  (chars.ready),
  .in_last   (chars.last),
  .out_valid (verdicts.valid),
  .out_ready (verdicts.ready),
  .verdict   (verdicts.verdict)
);
